### sv/prlenc_pkg.sv
// Shared types, constants and header encoding for the pixel run length encoder.
`default_nettype none
package prlenc_pkg;

    localparam int MAX_RUN = 32;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam int LEN_W   = $clog2(MAX_RUN);
    localparam int PIX_W   = 16;
    localparam int WIDTH_W = 16;

    localparam logic [7:0] HDR_LITERAL = 8'h00;
    localparam logic [7:0] HDR_TRANS   = 8'h20;
    localparam logic [7:0] HDR_REPEAT  = 8'h40;
    localparam logic [7:0] HDR_NEWLINE = 8'h80;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_TRANS,
        MODE_SAME,
        MODE_LIT
    } mode_t;

    typedef enum logic [2:0] {
        ST_IN,
        ST_GO,
        ST_HDR,
        ST_SPIX,
        ST_LRD,
        ST_LPIX,
        ST_NL
    } state_t;

    // one token to be closed: kind, length minus one, repeated pixel
    typedef struct packed {
        logic             vld;
        mode_t            mode;
        logic [LEN_W-1:0] len;
        logic [PIX_W-1:0] pix;
    } close_job_t;

    function automatic logic [PIX_W-1:0] hdr_word(input mode_t m, input logic [LEN_W-1:0] len);
        logic [7:0] hdr;
        hdr = HDR_LITERAL;
        case (m)
            MODE_TRANS: hdr = HDR_TRANS | 8'(len);
            MODE_SAME:  hdr = (len != '0) ? (HDR_REPEAT | 8'(len)) : HDR_LITERAL;
            MODE_LIT:   hdr = HDR_LITERAL | 8'(len);
            default:    hdr = HDR_LITERAL;
        endcase
        return {{(PIX_W - 8){1'b0}}, hdr};
    endfunction

endpackage
`default_nettype wire

### sv/prlenc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module prlenc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/pixel_run_length_encoder.sv
// The first beat of a pixel's tokens goes through ST_GO, ST_HDR and the output register to m_*.
// A pixel that closes no token passes ST_GO only; else the sequencer adds a state per header
// or repeat-pixel beat, held while m_* stalls, and ST_LRD plus ST_LPIX per literal buffer pixel.
// Output beats are registered, so a new pixel is taken while the last beat still waits.
// Reset (aresetn low, synchronous): no open token, column zero, line_width 1, output empty.
// Top level: pixel run length encoder with literal buffer RAM and token sequencer.
`default_nettype none
module pixel_run_length_encoder
    import prlenc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [WIDTH_W-1:0] cfg_line_width,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [PIX_W-1:0]   s_pixel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [PIX_W-1:0]        m_word,
    output logic                    m_is_pixel,
    output logic                    m_last
);

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] col_reg;
    mode_t              mode_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [PIX_W-1:0]   prev_reg;

    close_job_t j1_reg, j2_reg, j1_c, j2_c, cur;
    logic       nl_reg, wr0_reg;
    logic       jsel_reg, jsel_next;
    logic [LEN_W-1:0] k_reg, k_next;

    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_word_reg;
    logic               m_is_pixel_reg, m_last_reg;

    // accept-cycle datapath
    logic [WIDTH_W:0]   col_sum;
    logic               line_end;
    logic               opaque, same;
    mode_t              m_mode, f_mode;
    logic [RUN_W-1:0]   m_run, f_run;
    logic [PIX_W-1:0]   m_prev;
    logic               acc_we, wr0_c;
    logic [LEN_W-1:0]   acc_waddr;

    // RAM port
    logic               ram_we;
    logic [LEN_W-1:0]   ram_waddr;
    logic [PIX_W-1:0]   ram_wdata, ram_rdata;

    // sequencer outputs
    logic               emit_valid, emit_is_pixel, emit_last, load, more;
    logic [PIX_W-1:0]   emit_word;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign col_sum  = {1'b0, col_reg} + (WIDTH_W + 1)'(1);
    assign line_end = col_sum >= {1'b0, width_reg};
    assign opaque   = s_pixel[PIX_W-1];
    assign same     = s_pixel == prev_reg;

    always_comb begin
        j1_c      = '{vld: 1'b0, mode: MODE_IDLE, len: '0, pix: prev_reg};
        m_mode    = mode_reg;
        m_run     = run_reg;
        m_prev    = prev_reg;
        acc_we    = 1'b0;
        acc_waddr = run_reg[LEN_W-1:0];
        wr0_c     = 1'b0;
        case (mode_reg)
            MODE_TRANS: begin
                if (!opaque) begin
                    m_run  = RUN_W'(run_reg + 1'b1);
                    m_prev = s_pixel;
                end else begin
                    j1_c.vld  = 1'b1;
                    j1_c.mode = MODE_TRANS;
                    j1_c.len  = LEN_W'(run_reg - 1'b1);
                    m_mode    = MODE_SAME;
                    m_run     = RUN_W'(1);
                    m_prev    = s_pixel;
                end
            end
            MODE_SAME: begin
                if (same) begin
                    m_run = RUN_W'(run_reg + 1'b1);
                end else if (run_reg > RUN_W'(1)) begin
                    j1_c.vld  = 1'b1;
                    j1_c.mode = MODE_SAME;
                    j1_c.len  = LEN_W'(run_reg - 1'b1);
                    m_mode    = opaque ? MODE_SAME : MODE_TRANS;
                    m_run     = RUN_W'(1);
                    m_prev    = s_pixel;
                end else begin
                    // single repeat pixel turns into a two-entry literal;
                    // entry 0 is written in the following cycle
                    acc_we    = 1'b1;
                    acc_waddr = LEN_W'(1);
                    wr0_c     = 1'b1;
                    m_mode    = MODE_LIT;
                    m_run     = RUN_W'(2);
                    m_prev    = s_pixel;
                end
            end
            MODE_LIT: begin
                if (same) begin
                    // the last literal pixel moves into the new token
                    j1_c.vld  = 1'b1;
                    j1_c.mode = MODE_LIT;
                    j1_c.len  = LEN_W'(run_reg - RUN_W'(2));
                    m_mode    = opaque ? MODE_SAME : MODE_TRANS;
                    m_run     = RUN_W'(2);
                    m_prev    = s_pixel;
                end else begin
                    acc_we = 1'b1;
                    m_run  = RUN_W'(run_reg + 1'b1);
                    m_prev = s_pixel;
                end
            end
            default: begin
                m_mode = opaque ? MODE_SAME : MODE_TRANS;
                m_run  = RUN_W'(1);
                m_prev = s_pixel;
            end
        endcase

        j2_c.vld  = (m_mode != MODE_IDLE) && (line_end || (m_run >= RUN_W'(MAX_RUN)));
        j2_c.mode = m_mode;
        j2_c.len  = LEN_W'(m_run - 1'b1);
        j2_c.pix  = m_prev;
        f_mode    = j2_c.vld ? MODE_IDLE : m_mode;
        f_run     = j2_c.vld ? '0 : m_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_W'(1);
            col_reg   <= '0;
            mode_reg  <= MODE_IDLE;
            run_reg   <= '0;
            prev_reg  <= '0;
            j1_reg    <= '0;
            j2_reg    <= '0;
            nl_reg    <= 1'b0;
            wr0_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg <= cfg_line_width;
            end
            if (accept) begin
                col_reg  <= line_end ? '0 : col_sum[WIDTH_W-1:0];
                mode_reg <= f_mode;
                run_reg  <= f_run;
                prev_reg <= m_prev;
                j1_reg   <= j1_c;
                j2_reg   <= j2_c;
                nl_reg   <= line_end;
                wr0_reg  <= wr0_c;
            end
        end
    end

    // literal buffer write port: accept-cycle append, or deferred entry 0
    always_comb begin
        if (state_reg == ST_GO) begin
            ram_we    = wr0_reg;
            ram_waddr = '0;
            ram_wdata = j1_reg.pix;
        end else begin
            ram_we    = accept && acc_we;
            ram_waddr = acc_waddr;
            ram_wdata = s_pixel;
        end
    end

    prlenc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_RUN)
    ) u_lit_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign cur  = jsel_reg ? j2_reg : j1_reg;
    assign more = (!jsel_reg && j2_reg.vld) || nl_reg;
    assign load = emit_valid && (!m_valid_reg || m_ready);

    // sequencer outputs
    always_comb begin
        s_ready       = 1'b0;
        emit_valid    = 1'b0;
        emit_word     = cur.pix;
        emit_is_pixel = 1'b0;
        emit_last     = 1'b0;
        unique case (state_reg)
            ST_IN: s_ready = 1'b1;
            ST_GO: ;
            ST_HDR: begin
                emit_valid = 1'b1;
                emit_word  = hdr_word(cur.mode, cur.len);
                emit_last  = (cur.mode == MODE_TRANS) && !more;
            end
            ST_SPIX: begin
                emit_valid    = 1'b1;
                emit_is_pixel = 1'b1;
                emit_last     = !more;
            end
            ST_LRD: ;
            ST_LPIX: begin
                emit_valid    = 1'b1;
                emit_word     = ram_rdata;
                emit_is_pixel = 1'b1;
                emit_last     = (k_reg == cur.len) && !more;
            end
            ST_NL: begin
                emit_valid = 1'b1;
                emit_word  = {{(PIX_W - 8){1'b0}}, HDR_NEWLINE};
                emit_last  = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        state_t done_state;
        logic   done_jsel;
        state_next = state_reg;
        jsel_next  = jsel_reg;
        k_next     = k_reg;
        done_jsel  = jsel_reg;
        if (!jsel_reg && j2_reg.vld) begin
            done_state = ST_HDR;
            done_jsel  = 1'b1;
        end else if (nl_reg) begin
            done_state = ST_NL;
        end else begin
            done_state = ST_IN;
        end
        unique case (state_reg)
            ST_IN: begin
                if (s_valid) begin
                    state_next = ST_GO;
                end
            end
            ST_GO: begin
                if (j1_reg.vld) begin
                    state_next = ST_HDR;
                    jsel_next  = 1'b0;
                end else if (j2_reg.vld) begin
                    state_next = ST_HDR;
                    jsel_next  = 1'b1;
                end else if (nl_reg) begin
                    state_next = ST_NL;
                end else begin
                    state_next = ST_IN;
                end
            end
            ST_HDR: begin
                if (load) begin
                    case (cur.mode)
                        MODE_SAME: state_next = ST_SPIX;
                        MODE_LIT: begin
                            state_next = ST_LRD;
                            k_next     = '0;
                        end
                        default: begin
                            state_next = done_state;
                            jsel_next  = done_jsel;
                        end
                    endcase
                end
            end
            ST_SPIX: begin
                if (load) begin
                    state_next = done_state;
                    jsel_next  = done_jsel;
                end
            end
            ST_LRD: state_next = ST_LPIX;
            ST_LPIX: begin
                if (load) begin
                    if (k_reg == cur.len) begin
                        state_next = done_state;
                        jsel_next  = done_jsel;
                    end else begin
                        k_next     = LEN_W'(k_reg + 1'b1);
                        state_next = ST_LRD;
                    end
                end
            end
            ST_NL: begin
                if (load) begin
                    state_next = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IN;
            jsel_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            jsel_reg  <= jsel_next;
            k_reg     <= k_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_word_reg     <= emit_word;
            m_is_pixel_reg <= emit_is_pixel;
            m_last_reg     <= emit_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_word     = m_word_reg;
    assign m_is_pixel = m_is_pixel_reg;
    assign m_last     = m_last_reg;

endmodule
`default_nettype wire

### sv/prlenc_checker.sv
// Port-level checker for the pixel run length encoder, bound to the top level.
`default_nettype none
module prlenc_checker
    import prlenc_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [PIX_W-1:0]   m_word,
    input wire logic               m_is_pixel,
    input wire logic               m_last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word) && $stable(m_is_pixel)
            && $stable(m_last))
        else $error("output beat changed while stalled");

    // a newline beat always carries last
    a_newline_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_pixel && (m_word == {{(PIX_W - 8){1'b0}}, HDR_NEWLINE}) |-> m_last)
        else $error("newline beat without last");

    // header beats carry a byte only
    a_hdr_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_pixel |-> m_word[PIX_W-1:8] == '0)
        else $error("header beat with upper bits set");

    // a pixel is never followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind pixel_run_length_encoder prlenc_checker u_prlenc_checker (.*);
`default_nettype wire
